[hw/rtl/rgba_alpha_compositor_assert.svh]
// Assertion macros for the RGBA alpha compositor checker.
// Standalone; pulled in by rac_checker.sv.
`ifndef RGBA_ALPHA_COMPOSITOR_ASSERT_SVH
`define RGBA_ALPHA_COMPOSITOR_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define RAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rac: implication check failed");

// Next-cycle implication, masked while reset is asserted.
`define RAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rac: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define RAC_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rac: reset check failed");

`endif

[hw/rtl/rac_pkg.sv]
// Shared types, channel indexes, mode codes, divider staging and the divide-by-255
// helper for the RGBA alpha compositor. No dependencies.
package rac_pkg;

    localparam logic [7:0] ChanMax = 8'hff;

    // channel slots inside a packed pixel
    localparam int unsigned ChR = 0;
    localparam int unsigned ChG = 1;
    localparam int unsigned ChB = 2;
    localparam int unsigned ChA = 3;

    // un-premultiply divider: register stages and quotient bits per stage
    localparam int unsigned DivStages        = 4;
    localparam int unsigned DivStepsPerStage = 2;

    typedef enum logic [1:0] {
        FUNC_OVERLAY  = 2'd0,
        FUNC_UNDERLAY = 2'd1,
        FUNC_BLEND    = 2'd2,
        FUNC_DARKEN   = 2'd3
    } t_func;

    typedef logic [7:0]      t_chan;
    typedef logic [3:0][7:0] t_pix;

    // one beat between the compositing and the un-premultiply sections
    typedef struct packed {
        logic unpremul;
        t_pix chan;
    } t_beat;

    // floor(x / 255), exact for every product of two 8-bit values
    function automatic t_chan div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

[hw/rtl/rac_over.sv]
// Three-stage compositing pipeline: over/underlay, blend, darken and pass-through.
// Depends on rac_pkg.
module rac_over (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_func,
    input  rac_pkg::t_pix    i_dst,
    input  rac_pkg::t_pix    i_src,
    input  rac_pkg::t_chan   i_factor,
    output logic             o_valid,
    input  logic             i_stall,
    output rac_pkg::t_beat   o_beat
);

    typedef enum logic [1:0] {
        MODE_OVER,
        MODE_DARKEN,
        MODE_PASS
    } t_mode;

    logic en1, en2, en3;

    // stage 1: products
    logic            r1_valid;
    t_mode           r1_mode, n1_mode;
    logic            r1_unpremul, n1_unpremul;
    logic [15:0]     r1_up [3];
    logic [15:0]     r1_lo [3];
    logic [15:0]     n1_up [3];
    logic [15:0]     n1_lo [3];
    logic [15:0]     r1_ap, n1_ap;
    rac_pkg::t_chan  r1_au, r1_al;
    rac_pkg::t_pix   r1_dst;
    rac_pkg::t_pix   upper, lower;

    // stage 2: scaled terms and second product
    logic            r2_valid;
    t_mode           r2_mode;
    logic            r2_unpremul;
    rac_pkg::t_chan  r2_up [3];
    rac_pkg::t_chan  n2_up [3];
    logic [15:0]     r2_mul [3];
    logic [15:0]     n2_mul [3];
    rac_pkg::t_chan  r2_alt [3];
    rac_pkg::t_chan  n2_alt [3];
    rac_pkg::t_chan  r2_alpha, n2_alpha;

    // stage 3: result
    logic            r3_valid;
    rac_pkg::t_beat  r3_beat, n3_beat;

    assign en3     = !r3_valid || !i_stall;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_stall = !en1;
    assign o_valid = r3_valid;
    assign o_beat  = r3_beat;

    always_comb begin
        n1_mode     = MODE_PASS;
        n1_unpremul = 1'b0;
        upper       = i_src;
        lower       = i_dst;
        unique case (rac_pkg::t_func'(i_func))
            rac_pkg::FUNC_OVERLAY: begin
                n1_mode = MODE_OVER;
            end
            rac_pkg::FUNC_UNDERLAY: begin
                n1_mode = MODE_OVER;
                upper   = i_dst;
                lower   = i_src;
            end
            rac_pkg::FUNC_BLEND: begin
                // invisible source leaves the destination untouched
                if (i_src[rac_pkg::ChA] != 8'd0) begin
                    n1_mode     = MODE_OVER;
                    n1_unpremul = 1'b1;
                end
            end
            rac_pkg::FUNC_DARKEN: begin
                // lower product becomes c * f
                n1_mode                = MODE_DARKEN;
                lower[rac_pkg::ChA]    = i_factor;
            end
            default: n1_mode = MODE_PASS;
        endcase
        for (int ch = 0; ch < 3; ch++) begin
            n1_up[ch] = 16'(upper[ch]) * 16'(upper[rac_pkg::ChA]);
            n1_lo[ch] = 16'(lower[ch]) * 16'(lower[rac_pkg::ChA]);
        end
        n1_ap = 16'(upper[rac_pkg::ChA]) * 16'(rac_pkg::ChanMax - lower[rac_pkg::ChA]);
    end

    always_comb begin
        rac_pkg::t_chan lo;
        lo = '0;
        for (int ch = 0; ch < 3; ch++) begin
            lo         = rac_pkg::div255(r1_lo[ch]);
            n2_up[ch]  = rac_pkg::div255(r1_up[ch]);
            n2_mul[ch] = 16'(rac_pkg::ChanMax - r1_au) * 16'(lo);
            n2_alt[ch] = (r1_mode == MODE_DARKEN) ? r1_dst[ch] - lo : r1_dst[ch];
        end
        n2_alpha = (r1_mode == MODE_OVER) ? r1_al + rac_pkg::div255(r1_ap)
                                          : r1_dst[rac_pkg::ChA];
    end

    always_comb begin
        n3_beat.unpremul = r2_unpremul;
        for (int ch = 0; ch < 3; ch++) begin
            n3_beat.chan[ch] = (r2_mode == MODE_OVER)
                             ? r2_up[ch] + rac_pkg::div255(r2_mul[ch]) : r2_alt[ch];
        end
        n3_beat.chan[rac_pkg::ChA] = r2_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_mode     <= n1_mode;
            r1_unpremul <= n1_unpremul;
            r1_up       <= n1_up;
            r1_lo       <= n1_lo;
            r1_ap       <= n1_ap;
            r1_au       <= upper[rac_pkg::ChA];
            r1_al       <= lower[rac_pkg::ChA];
            r1_dst      <= i_dst;
        end
        if (en2) begin
            r2_mode     <= r1_mode;
            r2_unpremul <= r1_unpremul;
            r2_up       <= n2_up;
            r2_mul      <= n2_mul;
            r2_alt      <= n2_alt;
            r2_alpha    <= n2_alpha;
        end
        if (en3) begin
            r3_beat <= n3_beat;
        end
    end

endmodule

[hw/rtl/rac_unpremul.sv]
// Four-stage restoring divider: color * 255 / alpha, two quotient bits a stage,
// applied to blend beats only. Depends on rac_pkg.
module rac_unpremul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rac_pkg::t_beat  i_beat,
    output logic            o_valid,
    input  logic            i_stall,
    output rac_pkg::t_beat  o_beat
);

    logic [rac_pkg::DivStages-1:0] r_valid;
    logic [rac_pkg::DivStages-1:0] vin;
    logic [rac_pkg::DivStages-1:0] en;
    rac_pkg::t_beat    r_beat [rac_pkg::DivStages];
    rac_pkg::t_chan    r_rem  [rac_pkg::DivStages-1][3];
    rac_pkg::t_chan    r_num  [rac_pkg::DivStages-1][3];
    rac_pkg::t_chan    r_q    [rac_pkg::DivStages-1][3];

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [8:0] div_step(input rac_pkg::t_chan rem, input logic b,
                                            input rac_pkg::t_chan a);
        logic [8:0] t;
        logic [8:0] d;
        t = {rem, b};
        d = t - {1'b0, a};
        if (t >= {1'b0, a}) begin
            return {1'b1, d[7:0]};
        end
        return {1'b0, t[7:0]};
    endfunction

    assign vin = {r_valid[rac_pkg::DivStages-2:0], i_valid};

    always_comb begin
        en[rac_pkg::DivStages-1] = !r_valid[rac_pkg::DivStages-1] || !i_stall;
        for (int k = rac_pkg::DivStages - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_valid[rac_pkg::DivStages-1];
    assign o_beat  = r_beat[rac_pkg::DivStages-1];

    for (genvar k = 0; k < rac_pkg::DivStages; k++) begin : g_stg
        rac_pkg::t_beat in_beat;
        rac_pkg::t_chan in_rem [3];
        rac_pkg::t_chan in_num [3];
        rac_pkg::t_chan in_q   [3];
        rac_pkg::t_chan out_rem [3];
        rac_pkg::t_chan out_num [3];
        rac_pkg::t_chan out_q   [3];

        if (k == 0) begin : g_head
            always_comb begin
                logic [15:0] prod;
                prod = '0;
                in_beat = i_beat;
                for (int ch = 0; ch < 3; ch++) begin
                    // c * 255 = (c << 8) - c; high byte seeds the remainder
                    prod        = {i_beat.chan[ch], 8'd0} - {8'd0, i_beat.chan[ch]};
                    in_rem[ch]  = prod[15:8];
                    in_num[ch]  = prod[7:0];
                    in_q[ch]    = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                in_beat = r_beat[k-1];
                for (int ch = 0; ch < 3; ch++) begin
                    in_rem[ch] = r_rem[k-1][ch];
                    in_num[ch] = r_num[k-1][ch];
                    in_q[ch]   = r_q[k-1][ch];
                end
            end
        end

        always_comb begin
            logic [8:0]     st;
            rac_pkg::t_chan rem, num, q;
            st = '0;
            for (int ch = 0; ch < 3; ch++) begin
                rem = in_rem[ch];
                num = in_num[ch];
                q   = in_q[ch];
                for (int s = 0; s < rac_pkg::DivStepsPerStage; s++) begin
                    st  = div_step(rem, num[7], in_beat.chan[rac_pkg::ChA]);
                    rem = st[7:0];
                    num = {num[6:0], 1'b0};
                    q   = {q[6:0], st[8]};
                end
                out_rem[ch] = rem;
                out_num[ch] = num;
                out_q[ch]   = q;
            end
        end

        if (k < rac_pkg::DivStages - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_beat[k] <= in_beat;
                    r_rem[k]  <= out_rem;
                    r_num[k]  <= out_num;
                    r_q[k]    <= out_q;
                end
            end
        end else begin : g_tail
            rac_pkg::t_beat fin;
            always_comb begin
                fin = in_beat;
                if (in_beat.unpremul) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        // zero alpha gives 0; color at or above alpha clamps to 255
                        if (in_beat.chan[rac_pkg::ChA] == 8'd0) begin
                            fin.chan[ch] = 8'd0;
                        end else if (in_beat.chan[ch] >= in_beat.chan[rac_pkg::ChA]) begin
                            fin.chan[ch] = rac_pkg::ChanMax;
                        end else begin
                            fin.chan[ch] = out_q[ch];
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_beat[k] <= fin;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < rac_pkg::DivStages; k++) begin
                if (en[k]) r_valid[k] <= vin[k];
            end
        end
    end

endmodule

[hw/rtl/rgba_alpha_compositor.sv]
// RGBA alpha compositor top level: overlay, underlay, blend and darken on
// 8-bit RGBA pixels. Input channel: i_valid / o_stall with one port per field;
// output channel: o_valid / i_stall with the four result channels.
// A beat is taken at a rising edge with valid high and stall low.
// Pipeline: 3 compositing stages, then 4 divider stages that carry two quotient
// bits each. Throughput: one pixel per clock while i_stall stays low, set by
// the fully pipelined multipliers and the unrolled divider stages; every mode
// takes the same path.
// Stalls: each stage holds its beat only while the stage after it is full and
// blocked, so bubbles close up and input keeps flowing while the output waits.
// o_stall rises only once every stage is occupied and i_stall is high.
// A held output beat never changes.
// Reset (synchronous, active low) empties the pipeline; no state survives a
// beat, so there is no warm-up after reset.
// Depends on rac_pkg, rac_over and rac_unpremul.
module rgba_alpha_compositor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    input  logic [7:0] i_dst_alpha,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_darken_factor,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);

    rac_pkg::t_pix  dst, src;
    rac_pkg::t_beat mid_beat, out_beat;
    logic           mid_valid, mid_stall;

    always_comb begin
        dst[rac_pkg::ChR] = i_dst_red;
        dst[rac_pkg::ChG] = i_dst_green;
        dst[rac_pkg::ChB] = i_dst_blue;
        dst[rac_pkg::ChA] = i_dst_alpha;
        src[rac_pkg::ChR] = i_src_red;
        src[rac_pkg::ChG] = i_src_green;
        src[rac_pkg::ChB] = i_src_blue;
        src[rac_pkg::ChA] = i_src_alpha;
    end

    rac_over u_over (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_func   (i_func),
        .i_dst    (dst),
        .i_src    (src),
        .i_factor (i_darken_factor),
        .o_valid  (mid_valid),
        .i_stall  (mid_stall),
        .o_beat   (mid_beat)
    );

    rac_unpremul u_unpremul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_stall (mid_stall),
        .i_beat  (mid_beat),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_beat  (out_beat)
    );

    assign o_out_red   = out_beat.chan[rac_pkg::ChR];
    assign o_out_green = out_beat.chan[rac_pkg::ChG];
    assign o_out_blue  = out_beat.chan[rac_pkg::ChB];
    assign o_out_alpha = out_beat.chan[rac_pkg::ChA];

endmodule

[hw/rtl/rac_checker.sv]
// Port-level checks for rgba_alpha_compositor, bound to the top level.
// Depends on rgba_alpha_compositor_assert.svh.
`include "rgba_alpha_compositor_assert.svh"

module rac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue,
    input logic [7:0] o_out_alpha
);

    logic [31:0] out_pix;

    assign out_pix = {o_out_alpha, o_out_blue, o_out_green, o_out_red};

    // reset empties the pipe
    `RAC_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !o_valid)

    // a blocked result stays put
    `RAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_pix))

    // backpressure only comes from a blocked output beat
    `RAC_ASSERT_IMPL(a_no_false_stall, i_clk, i_rst_n, !(o_valid && i_stall), !o_stall)

endmodule

bind rgba_alpha_compositor rac_checker u_rac_checker (.*);
